>>> src/lpg_pkg.sv
// Shared constants, types and state encoding for the permutation generator.
package lpg_pkg;

  // Width of one permutation element and of the size register.
  localparam int unsigned ElemW          = 3;
  localparam int unsigned SizeW          = 4;
  // Number of position ports on the result channel.
  localparam int unsigned NumPos         = 8;
  // Default number of cells.
  localparam int unsigned MaxElementsDef = 8;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StPivot,
    StSwap,
    StSort,
    StEmit
  } lpg_state_e;

  // Per-cell command from the sequencer.
  typedef struct packed {
    logic load_ident;  // take the identity value
    logic load_ext;    // take the swap value for this cell
    logic cmp_right;   // compare-exchange with the right neighbor
    logic cmp_left;    // compare-exchange with the left neighbor
  } lpg_cell_ctrl_t;

endpackage

>>> src/lexicographic_permutation_generator.sv
// Top level: lexicographic permutation generator built from a row of element cells.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o   | restart_i
//   out     | output    | out_valid_o / out_stall_i | position_0_o..7_o, last_permutation_o
//   cfg     | input     | cfg_we_i (no wait)        | cfg_wdata_i (size_in_use)
//
// A restart (or first) request steps through accept, then result register load.
// An advance steps through accept, pivot search, swap, one odd-even transposition
// round per tail entry behind the pivot when there are at least two, and result load;
// with one tail entry it skips the sort, and the wrap to the identity goes from the
// pivot search straight to the result load.
// Reset clears the sequencer, the started flag and the result valid; the size
// returns to the full cell count. A stalled result holds in the output register
// and the sequencer waits in its last step until that register frees up.
module lexicographic_permutation_generator #(
  parameter int unsigned MAX_ELEMENTS = lpg_pkg::MaxElementsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [lpg_pkg::SizeW-1:0] cfg_wdata_i,
  // request channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      restart_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [lpg_pkg::ElemW-1:0] position_0_o,
  output logic [lpg_pkg::ElemW-1:0] position_1_o,
  output logic [lpg_pkg::ElemW-1:0] position_2_o,
  output logic [lpg_pkg::ElemW-1:0] position_3_o,
  output logic [lpg_pkg::ElemW-1:0] position_4_o,
  output logic [lpg_pkg::ElemW-1:0] position_5_o,
  output logic [lpg_pkg::ElemW-1:0] position_6_o,
  output logic [lpg_pkg::ElemW-1:0] position_7_o,
  output logic                      last_permutation_o
);
  import lpg_pkg::*;

  localparam int unsigned IdxW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  lpg_state_e       state_q, state_d;
  logic [SizeW-1:0] n_q, n_d;
  logic             started_q, started_d;
  logic [IdxW-1:0]  piv_q, piv_d;
  logic [SizeW-1:0] cnt_q, cnt_d;
  logic             phase_q, phase_d;
  logic             out_valid_q;
  logic [ElemW-1:0] pos_q [NumPos];
  logic             last_q;

  logic [ElemW-1:0]  val      [MAX_ELEMENTS];
  logic [ElemW-1:0]  ext      [MAX_ELEMENTS];
  logic [ElemW-1:0]  pos_nx   [NumPos];
  lpg_cell_ctrl_t    cell_ctrl[MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] lt_right;
  logic [MAX_ELEMENTS-1:0] asc;
  logic [MAX_ELEMENTS-1:0] pair_act;

  logic             accept, fresh, emit_ok;
  logic             ident_all, swap_en, sort_en, emit_load;
  logic [IdxW-1:0]  piv_idx, partner;
  logic             piv_found;
  logic [ElemW-1:0] piv_val;
  logic [SizeW-1:0] tail_len;
  logic [SizeW-1:0] n_wr;

  assign accept  = in_valid_i && (state_q == StIdle);
  assign fresh   = restart_i || !started_q;
  assign emit_ok = !out_valid_q || !out_stall_i;

  // Clamp a written size into 1..MAX_ELEMENTS.
  always_comb begin
    n_wr = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      n_wr = SizeW'(1);
    end else if (cfg_wdata_i > SizeW'(MAX_ELEMENTS)) begin
      n_wr = SizeW'(MAX_ELEMENTS);
    end
  end

  // Ascent flags and neighbor pairs inside the active range.
  always_comb begin
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      asc[k]      = lt_right[k] && (SizeW'(k + 1) < n_q);
      pair_act[k] = asc[k] || (SizeW'(k + 1) < n_q);
      pair_act[k] = pair_act[k] && (IdxW'(k) > piv_q) && ((k % 2 == 1) == phase_q);
    end
  end

  // Pivot: rightmost ascent.
  always_comb begin
    piv_idx = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (asc[k]) begin
        piv_idx = IdxW'(k);
      end
    end
  end
  assign piv_found = |asc;

  // Swap partner: rightmost tail entry above the pivot entry.
  assign piv_val = val[piv_q];
  always_comb begin
    partner = piv_q;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if ((IdxW'(k) > piv_q) && (SizeW'(k) < n_q) && (val[k] > piv_val)) begin
        partner = IdxW'(k);
      end
    end
  end

  assign tail_len = n_q - SizeW'(1) - SizeW'(piv_q);

  // Advance the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = fresh ? StEmit : StPivot;
        end
      end
      StPivot: begin
        state_d = piv_found ? StSwap : StEmit;
      end
      StSwap: begin
        state_d = (tail_len > SizeW'(1)) ? StSort : StEmit;
      end
      StSort: begin
        if (cnt_q == SizeW'(1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (emit_ok) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Drive the cell row and the bookkeeping registers.
  always_comb begin
    ident_all = cfg_we_i;
    swap_en   = 1'b0;
    sort_en   = 1'b0;
    emit_load = 1'b0;
    started_d = started_q;
    piv_d     = piv_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    n_d       = cfg_we_i ? n_wr : n_q;
    case (state_q)
      StIdle: begin
        if (accept && fresh) begin
          ident_all = 1'b1;
          started_d = 1'b1;
        end
      end
      StPivot: begin
        piv_d = piv_idx;
        if (!piv_found) begin
          ident_all = 1'b1;
        end
      end
      StSwap: begin
        swap_en = 1'b1;
        cnt_d   = tail_len;
        phase_d = ~piv_q[0];
      end
      StSort: begin
        sort_en = 1'b1;
        cnt_d   = cnt_q - SizeW'(1);
        phase_d = ~phase_q;
      end
      StEmit: begin
        emit_load = emit_ok;
      end
      default: begin
        emit_load = 1'b0;
      end
    endcase
    if (cfg_we_i) begin
      started_d = 1'b0;
    end
  end

  // Cell row.
  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    logic [ElemW-1:0] left_v, right_v;

    if (k == 0) begin : g_first
      assign left_v              = '0;
      assign cell_ctrl[k].cmp_left = 1'b0;
    end else begin : g_mid
      assign left_v              = val[k-1];
      assign cell_ctrl[k].cmp_left = sort_en && pair_act[k-1];
    end
    if (k == MAX_ELEMENTS - 1) begin : g_last
      assign right_v              = '0;
      assign cell_ctrl[k].cmp_right = 1'b0;
    end else begin : g_inner
      assign right_v              = val[k+1];
      assign cell_ctrl[k].cmp_right = sort_en && pair_act[k];
    end
    assign cell_ctrl[k].load_ident = ident_all;
    assign cell_ctrl[k].load_ext   = swap_en &&
                                     ((IdxW'(k) == piv_q) || (IdxW'(k) == partner));
    assign ext[k] = (IdxW'(k) == piv_q) ? val[partner] : piv_val;

    lpg_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[k]),
      .ident_i    (ElemW'(k)),
      .ext_i      (ext[k]),
      .left_i     (left_v),
      .right_i    (right_v),
      .val_o      (val[k]),
      .lt_right_o (lt_right[k])
    );
  end

  // Mask positions at or beyond n.
  for (genvar k = 0; k < NumPos; k++) begin : g_pos
    if (k < MAX_ELEMENTS) begin : g_live
      assign pos_nx[k] = (SizeW'(k) < n_q) ? val[k] : '0;
    end else begin : g_dead
      assign pos_nx[k] = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      started_q   <= 1'b0;
      n_q         <= SizeW'(MAX_ELEMENTS);
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      n_q       <= n_d;
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Work and result registers.
  always_ff @(posedge clk_i) begin
    piv_q   <= piv_d;
    cnt_q   <= cnt_d;
    phase_q <= phase_d;
    if (emit_load) begin
      pos_q  <= pos_nx;
      last_q <= ~piv_found;
    end
  end

  assign in_stall_o         = (state_q != StIdle);
  assign out_valid_o        = out_valid_q;
  assign position_0_o       = pos_q[0];
  assign position_1_o       = pos_q[1];
  assign position_2_o       = pos_q[2];
  assign position_3_o       = pos_q[3];
  assign position_4_o       = pos_q[4];
  assign position_5_o       = pos_q[5];
  assign position_6_o       = pos_q[6];
  assign position_7_o       = pos_q[7];
  assign last_permutation_o = last_q;

endmodule

>>> src/lpg_cell.sv
// One element cell: holds a permutation entry and exchanges with its neighbors.
module lpg_cell (
  input  logic                        clk_i,
  input  lpg_pkg::lpg_cell_ctrl_t     ctrl_i,
  input  logic [lpg_pkg::ElemW-1:0]   ident_i,
  input  logic [lpg_pkg::ElemW-1:0]   ext_i,
  input  logic [lpg_pkg::ElemW-1:0]   left_i,
  input  logic [lpg_pkg::ElemW-1:0]   right_i,
  output logic [lpg_pkg::ElemW-1:0]   val_o,
  output logic                        lt_right_o
);
  import lpg_pkg::*;

  logic [ElemW-1:0] val_q, val_d;

  // Select the next entry: reload, swap, or one compare-exchange step.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.load_ident) begin
      val_d = ident_i;
    end else if (ctrl_i.load_ext) begin
      val_d = ext_i;
    end else if (ctrl_i.cmp_right && (val_q > right_i)) begin
      val_d = right_i;
    end else if (ctrl_i.cmp_left && (left_i > val_q)) begin
      val_d = left_i;
    end
  end

  // Hold the entry; it is always reloaded before first use.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o      = val_q;
  assign lt_right_o = (val_q < right_i);

endmodule
